// ===== rtl/beq_pkg.sv =====
package beq_pkg;

  localparam int STORE_DEPTH_DEF = 32;
  localparam int EVENT_WIDTH_DEF = 64;

  localparam logic [5:0]  CAPACITY_RESET    = 6'd32;
  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_DRAIN   = 2'd1,
    OP_CLEAR   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    STS_ACCEPTED = 3'd0,
    STS_DROPPED  = 3'd1,
    STS_DRAINED  = 3'd2,
    STS_EMPTY    = 3'd3,
    STS_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_QUEUE_CAPACITY = 2'd0,
    CFG_MAX_PAYLOAD    = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SEND
  } state_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] event_word;
    logic [15:0] payload_length;
    logic [5:0]  max_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] out_event;
    logic [15:0] out_length;
    logic        last;
    logic [31:0] accepted_total;
    logic [31:0] drained_total;
    logic [31:0] dropped_total;
    logic [31:0] backpressure_total;
    logic [5:0]  depth_now;
    logic [5:0]  high_water;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic enq;
    logic drain_start;
    logic pop;
    logic clr;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic admit;
    logic empty;
    logic last;
  } sts_t;

  typedef struct packed {
    logic [31:0] accepted_total;
    logic [31:0] drained_total;
    logic [31:0] dropped_total;
    logic [31:0] backpressure_total;
    logic [5:0]  depth_now;
    logic [5:0]  high_water;
  } stats_t;

endpackage

// ===== rtl/beq_ctrl.sv =====
module beq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  input  logic               out_stall,
  input  beq_pkg::sts_t      sts,
  output logic               in_stall,
  output logic               out_valid,
  output beq_pkg::status_t   status,
  output logic               last,
  output beq_pkg::cmd_t      cmd
);

  beq_pkg::state_t  state_r, state_nxt;
  beq_pkg::status_t status_r, status_nxt;
  logic             last_r, last_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= beq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    last_r   <= last_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    last_nxt   = last_r;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state_r)
      beq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          case (in_op)
            beq_pkg::OP_ENQUEUE: begin
              cmd.enq    = 1'b1;
              status_nxt = sts.admit ? beq_pkg::STS_ACCEPTED : beq_pkg::STS_DROPPED;
              last_nxt   = 1'b1;
              state_nxt  = beq_pkg::S_SEND;
            end
            beq_pkg::OP_DRAIN: begin
              if (sts.empty) begin
                status_nxt = beq_pkg::STS_EMPTY;
                last_nxt   = 1'b1;
                state_nxt  = beq_pkg::S_SEND;
              end else begin
                cmd.drain_start = 1'b1;
                state_nxt       = beq_pkg::S_READ;
              end
            end
            beq_pkg::OP_CLEAR: begin
              cmd.clr    = 1'b1;
              status_nxt = beq_pkg::STS_CLEARED;
              last_nxt   = 1'b1;
              state_nxt  = beq_pkg::S_SEND;
            end
            default: begin
              state_nxt = beq_pkg::S_IDLE;
            end
          endcase
        end
      end
      beq_pkg::S_READ: begin
        cmd.pop    = 1'b1;
        status_nxt = beq_pkg::STS_DRAINED;
        last_nxt   = sts.last;
        state_nxt  = beq_pkg::S_SEND;
      end
      beq_pkg::S_SEND: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = last_r ? beq_pkg::S_IDLE : beq_pkg::S_READ;
        end
      end
      default: begin
        state_nxt = beq_pkg::S_IDLE;
      end
    endcase
  end

  assign status = status_r;
  assign last   = last_r;

endmodule

// ===== rtl/beq_datapath.sv =====
module beq_datapath #(
  parameter int STORE_DEPTH = beq_pkg::STORE_DEPTH_DEF,
  parameter int EVENT_WIDTH = beq_pkg::EVENT_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  beq_pkg::in_item_t       in_data,
  input  logic                    cfg_wr,
  input  logic [1:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  input  beq_pkg::cmd_t           cmd,
  output beq_pkg::sts_t           sts,
  output beq_pkg::stats_t         stats,
  output logic [EVENT_WIDTH-1:0]  rd_event,
  output logic [15:0]             rd_length
);

  localparam int PTR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = $clog2(STORE_DEPTH + 1);

  logic [EVENT_WIDTH-1:0] event_mem [STORE_DEPTH];
  logic [15:0]            length_mem [STORE_DEPTH];

  logic [5:0]             capacity_r;
  logic [15:0]            max_payload_r;
  logic [PTR_W-1:0]       rd_ptr_r, wr_ptr_r;
  logic [CNT_W-1:0]       count_r, peak_r, rem_r;
  logic [31:0]            accepted_r, drained_r, dropped_r, backpressure_r;
  logic [EVENT_WIDTH-1:0] rd_event_r;
  logic [15:0]            rd_length_r;

  logic                   admit;
  logic [CNT_W-1:0]       drain_n;
  logic [CNT_W-1:0]       count_inc;

  always_comb begin
    admit = (in_data.payload_length <= max_payload_r) &&
            (32'(count_r) < 32'(capacity_r)) && (32'(count_r) < STORE_DEPTH);
    if (in_data.max_count == '0 || 32'(in_data.max_count) > 32'(count_r)) begin
      drain_n = count_r;
    end else begin
      drain_n = CNT_W'(in_data.max_count);
    end
    count_inc = count_r + CNT_W'(1);
  end

  function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (32'(p) == STORE_DEPTH - 1) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= beq_pkg::CAPACITY_RESET;
      max_payload_r <= beq_pkg::MAX_PAYLOAD_RESET;
    end else if (cfg_wr) begin
      case (cfg_index)
        beq_pkg::CFG_QUEUE_CAPACITY: capacity_r    <= cfg_data[5:0];
        beq_pkg::CFG_MAX_PAYLOAD:    max_payload_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr) begin
      rd_ptr_r       <= '0;
      wr_ptr_r       <= '0;
      count_r        <= '0;
      peak_r         <= '0;
      accepted_r     <= '0;
      drained_r      <= '0;
      dropped_r      <= '0;
      backpressure_r <= '0;
      rem_r          <= '0;
    end else begin
      if (cmd.enq) begin
        if (admit) begin
          wr_ptr_r   <= next_slot(wr_ptr_r);
          count_r    <= count_inc;
          accepted_r <= accepted_r + 32'd1;
          if (count_inc > peak_r) begin
            peak_r <= count_inc;
          end
        end else begin
          dropped_r      <= dropped_r + 32'd1;
          backpressure_r <= backpressure_r + 32'd1;
        end
      end
      if (cmd.drain_start) begin
        count_r   <= count_r - drain_n;
        drained_r <= drained_r + 32'(drain_n);
        rem_r     <= drain_n;
      end
      if (cmd.pop) begin
        rd_ptr_r <= next_slot(rd_ptr_r);
        rem_r    <= rem_r - CNT_W'(1);
      end
    end
  end

  // store memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.enq && admit) begin
      event_mem[wr_ptr_r]  <= EVENT_WIDTH'(in_data.event_word);
      length_mem[wr_ptr_r] <= in_data.payload_length;
    end
    if (cmd.pop) begin
      rd_event_r  <= event_mem[rd_ptr_r];
      rd_length_r <= length_mem[rd_ptr_r];
    end
  end

  assign sts.admit = admit;
  assign sts.empty = (count_r == '0);
  assign sts.last  = (rem_r == CNT_W'(1));

  assign stats.accepted_total     = accepted_r;
  assign stats.drained_total      = drained_r;
  assign stats.dropped_total      = dropped_r;
  assign stats.backpressure_total = backpressure_r;
  assign stats.depth_now          = 6'(count_r);
  assign stats.high_water         = 6'(peak_r);

  assign rd_event  = rd_event_r;
  assign rd_length = rd_length_r;

endmodule

// ===== rtl/bounded_event_queue_with_drop_stats.sv =====
// Bounded event queue, drop-newest. An enqueue, a clear and an empty drain are
// each accepted; the single result appears in the next cycle and the block
// takes the next transaction in the cycle after that result is taken. An
// unused op is accepted, gives no result and the next transaction can follow
// right after it. A drain of n events is accepted and then, for each event,
// takes one registered read of the store memory followed by its result.
// Results of a drain all carry the statistics as they stand after the whole
// drain. Configuration writes are taken at any time (cfg_ready is tied high)
// and should only be made while the queue is idle. Store contents are not
// cleared by reset or by a clear.
module bounded_event_queue_with_drop_stats #(
  parameter int STORE_DEPTH = beq_pkg::STORE_DEPTH_DEF,
  parameter int EVENT_WIDTH = beq_pkg::EVENT_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  beq_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output beq_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  beq_pkg::cmd_t          cmd;
  beq_pkg::sts_t          sts;
  beq_pkg::stats_t        stats;
  beq_pkg::status_t       status;
  logic                   last;
  logic [EVENT_WIDTH-1:0] rd_event;
  logic [15:0]            rd_length;
  logic                   drained;

  assign cfg_ready = 1'b1;

  beq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.op),
    .out_stall (out_stall),
    .sts       (sts),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .status    (status),
    .last      (last),
    .cmd       (cmd)
  );

  beq_datapath #(
    .STORE_DEPTH (STORE_DEPTH),
    .EVENT_WIDTH (EVENT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .stats     (stats),
    .rd_event  (rd_event),
    .rd_length (rd_length)
  );

  assign drained = (status == beq_pkg::STS_DRAINED);

  always_comb begin
    out_data.status             = status;
    out_data.out_event          = drained ? 64'(rd_event) : '0;
    out_data.out_length         = drained ? rd_length : '0;
    out_data.last               = last;
    out_data.accepted_total     = stats.accepted_total;
    out_data.drained_total      = stats.drained_total;
    out_data.dropped_total      = stats.dropped_total;
    out_data.backpressure_total = stats.backpressure_total;
    out_data.depth_now          = stats.depth_now;
    out_data.high_water         = stats.high_water;
  end

  // no new transaction while a result is pending
  a_no_accept_while_result: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input taken while a result is pending");

  // only drained results may be non-final
  a_non_last_is_drain: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last |-> out_data.status == beq_pkg::STS_DRAINED)
    else $error("non-final result that is not a drained event");

  // a non-final drained result is followed by a read cycle and the next result
  a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> !out_valid ##1 out_valid)
    else $error("drain stopped before its final result");

endmodule
